FILE: src/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 stream encoder.
// Shared codes, byte-pattern constants and the job record passed front to back.
// No dependencies.
`default_nettype none
package u16u8_pkg;

  // status codes carried in tuser
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ROOM = 2'd1;
  localparam logic [1:0] ST_SURR = 2'd2;

  // widths fixed by the stream fields
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned OFF_W  = 24;
  localparam int unsigned BUF_W  = 24;

  // UTF-8 lead and continuation prefixes
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  // UTF-16 range limits
  localparam logic [15:0] MAX1    = 16'h007F;
  localparam logic [15:0] MAX2    = 16'h07FF;
  localparam logic [5:0]  HI_TAG  = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  LO_TAG  = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // job queue size
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  // one job: up to four bytes laid out at consecutive offsets
  typedef struct packed {
    logic [3:0][7:0]   bytes;
    logic [1:0]        last_idx;
    logic [OFF_W-1:0]  base;
    logic              term;
    logic [1:0]        status;
  } job_t;

  // front status seen by the top level
  typedef struct packed {
    logic [1:0] err;
    logic       pending;
  } front_stat_t;

endpackage
`default_nettype wire

FILE: src/utf16_to_utf8_stream_encoder.sv
// UTF-16 to UTF-8 stream encoder, top level.
// Instantiates u16u8_front, u16u8_queue and u16u8_back; uses u16u8_pkg.
//
// Usage:
//   in_*  : one UTF-16 code unit per beat; a zero unit ends a string.
//   out_* : one UTF-8 byte per beat with its buffer offset; tlast marks the
//           final byte for a code unit, tuser carries terminator and status.
//   cfg_* : write of the buffer length in bytes, taken every cycle.
// A BMP unit gives 1 to 3 bytes, a surrogate pair 4 bytes on the low unit,
// a high surrogate none. An error (buffer too small, unpaired surrogate) is
// sticky: every later unit gives one beat with nonzero status until reset.
// The first byte of a unit passes through the job queue and then the output
// register of the byte sequencer before it is presented.
// Throughput: one output byte per cycle while out_tready is high (or the
// output register is empty), set by the byte sequencer; the input is taken
// while the four-entry job queue has room, independent of the output side.
// Reset (rst_n low, synchronous) clears counter, surrogate, error and queue,
// and sets the buffer length to 0xFFFFFF. When the receiver stalls, the
// output beat holds and the queue fills, then in_tready drops.
`default_nettype none
module utf16_to_utf8_stream_encoder #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [15:0] code_unit
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [7:0] out_byte, [31:8] byte_offset
  output logic             out_tlast,   // last_of_unit
  output logic [2:0]       out_tuser,   // [0] string_end, [2:1] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_data     // buffer_bytes
);
  import u16u8_pkg::*;

  logic [BUF_W-1:0] buf_r;
  logic             space, push, pop, full, empty;
  job_t             wr_job, rd_job;
  front_stat_t      fstat;
  logic [7:0]       o_byte;
  logic [OFF_W-1:0] o_off;
  logic             o_last, o_term;
  logic [1:0]       o_st;

  // buffer length register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      buf_r <= cfg_data;
    end
  end

  assign space = !full;

  u16u8_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .unit_valid   (in_tvalid),
    .unit         (in_tdata),
    .space        (space),
    .buffer_bytes (buf_r),
    .unit_ready   (in_tready),
    .job_push     (push),
    .job          (wr_job),
    .stat         (fstat)
  );

  u16u8_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (full),
    .empty  (empty)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (rd_job),
    .job_empty  (empty),
    .job_pop    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (o_byte),
    .out_off    (o_off),
    .out_last   (o_last),
    .out_term   (o_term),
    .out_status (o_st)
  );

  assign out_tdata = {o_off, o_byte};
  assign out_tlast = o_last;
  assign out_tuser = {o_st, o_term};

  // sticky error never changes once set
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fstat.err != ST_OK) |=> $stable(fstat.err))
    else $error("sticky error changed");

  // an error beat is a single zero byte closing its unit
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:1] != ST_OK)) |->
      (out_tlast && (out_tdata[7:0] == 8'd0) && !out_tuser[0]))
    else $error("malformed error beat");

  // a terminator is a zero byte, alone for its unit
  a_term_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && (out_tdata[7:0] == 8'd0)))
    else $error("malformed terminator beat");

  // the unit that sets an error leaves the held-surrogate flag as it was
  a_err_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(fstat.err != ST_OK)) |-> ($stable(fstat.pending)))
    else $error("surrogate state moved on error");

endmodule
`default_nettype wire

FILE: src/u16u8_front.sv
// Front end: accepts code units, checks room and pairing, encodes bytes.
// Holds the surrogate, byte counter and sticky error. Uses u16u8_pkg.
`default_nettype none
module u16u8_front #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              unit_valid,
  input  wire logic [u16u8_pkg::UNIT_W-1:0]      unit,
  input  wire logic                              space,
  input  wire logic [u16u8_pkg::BUF_W-1:0]       buffer_bytes,
  output logic                                   unit_ready,
  output logic                                   job_push,
  output u16u8_pkg::job_t                        job,
  output u16u8_pkg::front_stat_t                 stat
);
  import u16u8_pkg::*;

  // compare width: wide enough for the counter plus four and the buffer size
  localparam int unsigned MW = (OFFSET_BITS > BUF_W) ? OFFSET_BITS : BUF_W;
  localparam int unsigned CW = MW + 1;
  localparam logic [CW-1:0] OFF_MAX = CW'((64'd1 << OFFSET_BITS) - 64'd1);

  logic [OFFSET_BITS-1:0] bw_r, bw_nxt;
  logic [9:0]             hi_r, hi_nxt;
  logic                   pend_r, pend_nxt;
  logic [1:0]             err_r, err_nxt;

  logic            take, is_hi, is_lo, push;
  logic [CW-1:0]   bw_ext, lim, buf_ext;
  logic [20:0]     cp;
  logic [2:0]      nbytes;
  job_t            jb;

  assign unit_ready = space;
  assign take       = unit_valid && space;
  assign is_hi      = (unit[15:10] == HI_TAG);
  assign is_lo      = (unit[15:10] == LO_TAG);
  assign bw_ext     = CW'(bw_r);
  assign buf_ext    = CW'(buffer_bytes);
  assign lim        = (buf_ext > OFF_MAX) ? OFF_MAX : buf_ext;
  assign cp         = SUPP_BASE + {1'b0, hi_r, unit[9:0]};

  // classify, encode and work out the next state
  always_comb begin
    bw_nxt   = bw_r;
    hi_nxt   = hi_r;
    pend_nxt = pend_r;
    err_nxt  = err_r;
    push     = 1'b1;
    nbytes   = 3'd0;
    jb.bytes    = '0;
    jb.last_idx = 2'd0;
    jb.base     = bw_ext[OFF_W-1:0];
    jb.term     = 1'b0;
    jb.status   = ST_OK;
    if (err_r != ST_OK) begin
      jb.status = err_r;
    end else if (pend_r != is_lo) begin
      err_nxt   = ST_SURR;
      jb.status = ST_SURR;
    end else if (unit == '0) begin
      if (bw_ext >= lim) begin
        err_nxt   = ST_ROOM;
        jb.status = ST_ROOM;
      end else begin
        jb.term = 1'b1;
        nbytes  = 3'd1;
      end
    end else if ((bw_ext + CW'(4)) >= lim) begin
      err_nxt   = ST_ROOM;
      jb.status = ST_ROOM;
    end else if (is_hi) begin
      hi_nxt   = unit[9:0];
      pend_nxt = 1'b1;
      push     = 1'b0;
    end else if (is_lo) begin
      hi_nxt      = '0;
      pend_nxt    = 1'b0;
      jb.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
      jb.bytes[1] = CONT  | {2'd0, cp[17:12]};
      jb.bytes[2] = CONT  | {2'd0, cp[11:6]};
      jb.bytes[3] = CONT  | {2'd0, cp[5:0]};
      jb.last_idx = 2'd3;
      nbytes      = 3'd4;
    end else if (unit <= MAX1) begin
      jb.bytes[0] = unit[7:0];
      nbytes      = 3'd1;
    end else if (unit <= MAX2) begin
      jb.bytes[0] = LEAD2 | {3'd0, unit[10:6]};
      jb.bytes[1] = CONT  | {2'd0, unit[5:0]};
      jb.last_idx = 2'd1;
      nbytes      = 3'd2;
    end else begin
      jb.bytes[0] = LEAD3 | {4'd0, unit[15:12]};
      jb.bytes[1] = CONT  | {2'd0, unit[11:6]};
      jb.bytes[2] = CONT  | {2'd0, unit[5:0]};
      jb.last_idx = 2'd2;
      nbytes      = 3'd3;
    end
    bw_nxt = bw_r + OFFSET_BITS'(nbytes);
  end

  assign job      = jb;
  assign job_push = take && push;
  assign stat.err     = err_r;
  assign stat.pending = pend_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r   <= '0;
      hi_r   <= '0;
      pend_r <= 1'b0;
      err_r  <= ST_OK;
    end else if (take) begin
      bw_r   <= bw_nxt;
      hi_r   <= hi_nxt;
      pend_r <= pend_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/u16u8_queue.sv
// Short job queue between the front end and the byte sequencer.
// Register based, first in first out. Uses u16u8_pkg.
`default_nettype none
module u16u8_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire u16u8_pkg::job_t wr_job,
  input  wire logic            pop,
  output u16u8_pkg::job_t      rd_job,
  output logic                 full,
  output logic                 empty
);
  import u16u8_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_job;
  end

endmodule
`default_nettype wire

FILE: src/u16u8_back.sv
// Back end: walks each queued job and sends one byte per beat.
// Output register decouples the downstream ready. Uses u16u8_pkg.
`default_nettype none
module u16u8_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire u16u8_pkg::job_t              job,
  input  wire logic                         job_empty,
  output logic                              job_pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [7:0]                        out_byte,
  output logic [u16u8_pkg::OFF_W-1:0]       out_off,
  output logic                              out_last,
  output logic                              out_term,
  output logic [1:0]                        out_status
);
  import u16u8_pkg::*;

  logic [1:0]       idx_r, idx_nxt;
  logic             vld_r, vld_nxt;
  logic [7:0]       byte_r;
  logic [OFF_W-1:0] off_r;
  logic             last_r, term_r;
  logic [1:0]       st_r;
  logic             load, fire, at_last;

  assign load    = !vld_r || out_tready;
  assign fire    = load && !job_empty;
  assign at_last = (idx_r == job.last_idx);
  assign job_pop = fire && at_last;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) vld_nxt = !job_empty;
    if (fire) idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= job.bytes[idx_r];
      off_r  <= job.base + OFF_W'(idx_r);
      last_r <= at_last;
      term_r <= job.term;
      st_r   <= job.status;
    end
  end

  assign out_tvalid = vld_r;
  assign out_byte   = byte_r;
  assign out_off    = off_r;
  assign out_last   = last_r;
  assign out_term   = term_r;
  assign out_status = st_r;

endmodule
`default_nettype wire
